### rtl/gif_block_structure_walker_defines.svh
// Assertion helpers shared by the walker RTL.
`ifndef GIF_BLOCK_STRUCTURE_WALKER_DEFINES_SVH
`define GIF_BLOCK_STRUCTURE_WALKER_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define GBSW_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gbsw assertion failed");

// Next-cycle implication, off while reset is held.
`define GBSW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gbsw assertion failed");

`endif

### rtl/gbsw_pkg.sv
package gbsw_pkg;

    typedef enum logic [3:0] {
        PH_SIG      = 4'd0,
        PH_HDR      = 4'd1,
        PH_BLOCK    = 4'd2,
        PH_IMGHEAD  = 4'd3,
        PH_CODESIZE = 4'd4,
        PH_SUB      = 4'd5,
        PH_EXTHEAD  = 4'd6
    } phase_t;

    typedef enum logic [1:0] {
        VERDICT_INVALID    = 2'd0,
        VERDICT_COMPLETE   = 2'd1,
        VERDICT_INCOMPLETE = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } gbsw_in_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [31:0] parsed_length;
    } gbsw_out_t;

    localparam logic [7:0] BYTE_TRAILER = 8'h3B;
    localparam logic [7:0] BYTE_IMAGE   = 8'h2C;
    localparam logic [7:0] BYTE_EXT     = 8'h21;

    // Header layout positions.
    localparam int SIG_LAST_POS = 5;
    localparam int PACKED_POS   = 10;
    localparam int HDR_LAST_POS = 12;
    localparam int SCREEN_END   = 13;
    localparam int MIN_FILE_LEN = 13;

    // Addends applied on top of position + 1.
    localparam logic [9:0] IMAGE_DESC_ADD = 10'd8;
    localparam logic [9:0] EXT_HEAD_ADD   = 10'd1;

    // Signature byte at index idx; v89 picks the 89a variant.
    function automatic logic [7:0] sig_char(input logic [2:0] idx, input logic v89);
        logic [7:0] c;
        begin
            case (idx)
                3'd0: c = 8'h47;
                3'd1: c = 8'h49;
                3'd2: c = 8'h46;
                3'd3: c = 8'h38;
                3'd4: c = v89 ? 8'h39 : 8'h37;
                3'd5: c = 8'h61;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // Size in bytes of a color table announced by a packed field.
    function automatic logic [9:0] table_bytes(input logic [7:0] packed_field);
        logic [3:0] shamt;
        begin
            shamt = {1'b0, packed_field[2:0]} + 4'd1;
            return packed_field[7] ? (10'd3 << shamt) : 10'd0;
        end
    endfunction

endpackage

### rtl/gif_block_structure_walker.sv
// GIF block-structure walker.
// Input channel s_valid/s_ready/s_data carries one file byte per transaction,
// with last_byte set on the final byte of a file. The walker checks the
// signature, skips the screen descriptor and color tables, and follows image
// descriptors, extensions and sub-blocks. Each file yields exactly one
// transaction on m_valid/m_ready/m_data: invalid, complete (trailer seen) or
// incomplete, with the offset the walk reached. Bytes after the verdict, up
// to the last one, are consumed silently.
// Throughput: one byte per cycle while the result side does not stall. Each
// byte waits in the input register, where a single compare-and-add pass
// updates the walk state and loads the result register as the byte leaves
// it; a result is visible in the result register and is taken from there.
// The walk state is registered and feeds back into that pass.
// A stalled m_ready holds the result register; the input register then
// fills and s_ready drops until the result is taken.
// Synchronous active-low reset empties both registers and restarts the walk
// at the signature; the walk also restarts after every last byte.
module gif_block_structure_walker
    import gbsw_pkg::*;
#(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  gbsw_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output gbsw_out_t m_data
);

`include "gif_block_structure_walker_defines.svh"

    localparam int OW = OFFSET_WIDTH;
    localparam logic [OW-1:0] OFS_MAX = '1;

    logic            in_valid_reg, in_valid_next;
    gbsw_in_t        in_data_reg, in_data_next;
    logic            out_valid_reg, out_valid_next;
    gbsw_out_t       out_data_reg, out_data_next;

    phase_t          phase_reg, phase_next;
    logic [OW-1:0]   pos_reg, pos_next;
    logic [OW-1:0]   offset_reg, offset_next;
    logic [OW-1:0]   start_reg, start_next;
    logic [1:0]      sigm_reg, sigm_next;
    logic            given_reg, given_next;

    phase_t          phase_walk;
    logic [OW-1:0]   offset_walk;
    logic [OW-1:0]   start_walk;
    logic [1:0]      sigm_walk;

    logic            fire;
    logic [7:0]      b;
    logic            last;
    logic            live;
    logic            hit;
    logic [1:0]      sigm_upd;
    logic [9:0]      tb;
    logic [9:0]      addend;
    logic [OW:0]     step_sum;
    logic [OW-1:0]   step_sat;
    logic [OW:0]     end_sum;
    logic [OW-1:0]   end_sat;
    logic [OW-1:0]   pos_inc;

    logic            res_valid;
    verdict_t        res_verdict;
    logic [OW-1:0]   res_len;
    logic [63:0]     res_len64;

    assign fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = out_valid_reg;
    assign m_data = out_data_reg;

    assign b = in_data_reg.data_byte;
    assign last = in_data_reg.last_byte;
    assign live = !given_reg && (pos_reg != OFS_MAX);
    assign hit = (pos_reg == offset_reg);
    assign tb = table_bytes(b);
    assign sigm_upd = sigm_reg & {b == sig_char(pos_reg[2:0], 1'b1),
                                  b == sig_char(pos_reg[2:0], 1'b0)};
    assign pos_inc = (pos_reg == OFS_MAX) ? pos_reg : pos_reg + OW'(1);

    // Shared skip adder: position + 1 + addend, saturating.
    always_comb begin
        case (phase_reg)
            PH_BLOCK:    addend = (b == BYTE_IMAGE) ? IMAGE_DESC_ADD : EXT_HEAD_ADD;
            PH_IMGHEAD:  addend = tb;
            PH_SUB:      addend = {2'b00, b};
            default:     addend = 10'd0;
        endcase
    end

    assign step_sum = {1'b0, pos_reg} + (OW + 1)'(addend) + (OW + 1)'(1);
    assign step_sat = step_sum[OW] ? OFS_MAX : step_sum[OW-1:0];
    assign end_sum = {1'b0, offset_walk} + (OW + 1)'(1);
    assign end_sat = end_sum[OW] ? OFS_MAX : end_sum[OW-1:0];

    // Walk state update for the byte in the input register.
    always_comb begin
        phase_walk  = phase_reg;
        offset_walk = offset_reg;
        start_walk  = start_reg;
        sigm_walk   = sigm_reg;
        if (live) begin
            case (phase_reg)
                PH_SIG: begin
                    sigm_walk = sigm_upd;
                    if (sigm_upd != 2'b00 && pos_reg >= OW'(SIG_LAST_POS)) begin
                        phase_walk = PH_HDR;
                    end
                end
                PH_HDR: begin
                    if (pos_reg == OW'(PACKED_POS)) begin
                        offset_walk = OW'(SCREEN_END) + OW'(tb);
                    end
                    if (pos_reg >= OW'(HDR_LAST_POS)) begin
                        phase_walk = PH_BLOCK;
                    end
                end
                PH_EXTHEAD: begin
                    phase_walk = PH_SUB;
                end
                PH_BLOCK: begin
                    if (hit && (b == BYTE_IMAGE || b == BYTE_EXT)) begin
                        start_walk  = pos_reg;
                        offset_walk = step_sat;
                        phase_walk  = (b == BYTE_IMAGE) ? PH_IMGHEAD : PH_EXTHEAD;
                    end
                end
                PH_IMGHEAD: begin
                    if (hit) begin
                        offset_walk = step_sat;
                        phase_walk  = PH_CODESIZE;
                    end
                end
                PH_CODESIZE: begin
                    if (hit) begin
                        offset_walk = step_sat;
                        phase_walk  = PH_SUB;
                    end
                end
                PH_SUB: begin
                    if (hit) begin
                        offset_walk = step_sat;
                        if (b == 8'h00) begin
                            phase_walk = PH_BLOCK;
                        end
                    end
                end
                default: begin
                    phase_walk = phase_reg;
                end
            endcase
        end
    end

    // Next state: restart after the last byte, else take the walk update.
    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        offset_next = offset_reg;
        start_next  = start_reg;
        sigm_next   = sigm_reg;
        given_next  = given_reg;
        if (fire) begin
            if (last) begin
                phase_next  = PH_SIG;
                pos_next    = '0;
                offset_next = '0;
                start_next  = '0;
                sigm_next   = 2'b11;
                given_next  = 1'b0;
            end else begin
                phase_next  = phase_walk;
                pos_next    = pos_inc;
                offset_next = offset_walk;
                start_next  = start_walk;
                sigm_next   = sigm_walk;
                given_next  = given_reg || res_valid;
            end
        end
    end

    // Result for the byte in the input register.
    always_comb begin
        res_valid   = 1'b0;
        res_verdict = VERDICT_INCOMPLETE;
        res_len     = '0;
        if (live && phase_reg == PH_SIG && sigm_upd == 2'b00) begin
            res_valid   = 1'b1;
            res_verdict = VERDICT_INVALID;
        end else if (live && phase_reg == PH_BLOCK && hit && b != BYTE_IMAGE
                     && b != BYTE_EXT) begin
            res_valid = 1'b1;
            if (b == BYTE_TRAILER) begin
                res_verdict = VERDICT_COMPLETE;
                res_len     = pos_reg + OW'(1);
            end else begin
                res_len = pos_reg;
            end
        end else if (last && !given_reg) begin
            res_valid = 1'b1;
            if (pos_reg < OW'(MIN_FILE_LEN)) begin
                res_verdict = VERDICT_INVALID;
            end else if (phase_walk == PH_IMGHEAD || phase_walk == PH_EXTHEAD) begin
                res_len = start_walk;
            end else if (phase_walk == PH_SUB) begin
                res_len = end_sat;
            end else begin
                res_len = offset_walk;
            end
        end
    end

    assign res_len64 = 64'(res_len);

    // Input and result registers.
    always_comb begin
        in_valid_next  = in_valid_reg;
        in_data_next   = in_data_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_data_next  = s_data;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        if (fire) begin
            out_valid_next = res_valid;
            out_data_next.verdict = res_verdict;
            out_data_next.parsed_length = (res_len64[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                                    : res_len64[31:0];
        end else if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_SIG;
            pos_reg       <= '0;
            offset_reg    <= '0;
            start_reg     <= '0;
            sigm_reg      <= 2'b11;
            given_reg     <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            offset_reg    <= offset_next;
            start_reg     <= start_next;
            sigm_reg      <= sigm_next;
            given_reg     <= given_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    `GBSW_ASSERT_IMPL(a_invalid_zero_len, aclk, aresetn,
        m_valid && m_data.verdict == VERDICT_INVALID, m_data.parsed_length == 32'd0)
    `GBSW_ASSERT_IMPL(a_one_verdict, aclk, aresetn, fire && res_valid, !given_reg)
    `GBSW_ASSERT_NEXT(a_restart, aclk, aresetn, fire && last,
        phase_reg == PH_SIG && pos_reg == '0 && !given_reg)
    `GBSW_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(out_data_reg))

endmodule

### tb/gif_block_structure_walker_test.sv
module gif_block_structure_walker_test;
    import gbsw_pkg::*;

    localparam longint unsigned OFS_LIMIT = 64'h0000_0000_FFFF_FFFF;
    localparam longint unsigned IMAGE_PACKED_OFS = 9;   // packed field of an image descriptor
    localparam longint unsigned EXT_FIRST_SUB_OFS = 2;  // first sub-block length after 0x21 and label
    localparam int CYCLE_LIMIT = 400000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    gbsw_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    gbsw_out_t m_data;

    gif_block_structure_walker i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Walk state mirrored from the byte stream.
    phase_t          walk_phase;
    longint unsigned walk_pos;
    longint unsigned walk_target;
    longint unsigned block_start;
    logic [1:0]      sig_alive;
    bit              verdict_done;

    gbsw_out_t   verdicts_due[$];
    logic [7:0]  file_bytes[$];
    bit          idling = 1'b1;
    int          stall_left = 0;
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          files_sent = 0;
    int          verdicts_seen = 0;
    int          seen_by_verdict[3] = '{0, 0, 0};
    int          cycle_count = 0;

    function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
        if (a >= OFS_LIMIT || b >= OFS_LIMIT - a) return OFS_LIMIT;
        return a + b;
    endfunction

    function automatic longint unsigned color_table_len(logic [7:0] flags);
        if (!flags[7]) return 64'd0;
        return 64'd3 << (int'(flags[2:0]) + 1);
    endfunction

    function automatic logic [7:0] sig_byte(int idx, bit v89);
        string sig;
        sig = v89 ? "GIF89a" : "GIF87a";
        return 8'(sig[idx]);
    endfunction

    function automatic void restart_walk();
        walk_phase   = PH_SIG;
        walk_pos     = 0;
        walk_target  = 0;
        block_start  = 0;
        sig_alive    = 2'b11;
        verdict_done = 1'b0;
    endfunction

    function automatic void expect_verdict(verdict_t v, longint unsigned len);
        gbsw_out_t r;
        r.verdict       = v;
        r.parsed_length = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
        verdicts_due.push_back(r);
        verdict_done = 1'b1;
    endfunction

    function automatic void walk_gif_byte(gbsw_in_t item);
        logic [7:0]      b;
        longint unsigned p;
        b = item.data_byte;
        p = walk_pos;
        if (!verdict_done && p < OFS_LIMIT) begin
            case (walk_phase)
                PH_SIG: begin
                    if (b != sig_byte(int'(p % 6), 1'b0)) sig_alive[0] = 1'b0;
                    if (b != sig_byte(int'(p % 6), 1'b1)) sig_alive[1] = 1'b0;
                    if (sig_alive == 2'b00) expect_verdict(VERDICT_INVALID, 64'd0);
                    else if (p >= SIG_LAST_POS) walk_phase = PH_HDR;
                end
                PH_HDR: begin
                    if (p == PACKED_POS)
                        walk_target = sat_sum(64'(SCREEN_END), color_table_len(b));
                    if (p >= HDR_LAST_POS) walk_phase = PH_BLOCK;
                end
                PH_EXTHEAD: walk_phase = PH_SUB;  // label byte, any value
                default: begin
                    if (p == walk_target) begin
                        case (walk_phase)
                            PH_BLOCK: begin
                                if (b == BYTE_TRAILER) begin
                                    expect_verdict(VERDICT_COMPLETE, sat_sum(p, 1));
                                end else if (b == BYTE_IMAGE) begin
                                    block_start = p;
                                    walk_target = sat_sum(p, IMAGE_PACKED_OFS);
                                    walk_phase  = PH_IMGHEAD;
                                end else if (b == BYTE_EXT) begin
                                    block_start = p;
                                    walk_target = sat_sum(p, EXT_FIRST_SUB_OFS);
                                    walk_phase  = PH_EXTHEAD;
                                end else begin
                                    expect_verdict(VERDICT_INCOMPLETE, p);
                                end
                            end
                            PH_IMGHEAD: begin
                                walk_target = sat_sum(sat_sum(p, 1), color_table_len(b));
                                walk_phase  = PH_CODESIZE;
                            end
                            PH_CODESIZE: begin
                                walk_target = sat_sum(p, 1);
                                walk_phase  = PH_SUB;
                            end
                            PH_SUB: begin
                                walk_target = sat_sum(sat_sum(p, 1), 64'(b));
                                if (b == 8'h00) walk_phase = PH_BLOCK;
                            end
                            default: walk_phase = PH_BLOCK;
                        endcase
                    end
                end
            endcase
        end
        if (item.last_byte) begin
            if (!verdict_done) begin
                if (p < MIN_FILE_LEN) expect_verdict(VERDICT_INVALID, 64'd0);
                else if (walk_phase == PH_IMGHEAD || walk_phase == PH_EXTHEAD)
                    expect_verdict(VERDICT_INCOMPLETE, block_start);
                else if (walk_phase == PH_SUB)
                    expect_verdict(VERDICT_INCOMPLETE, sat_sum(walk_target, 1));
                else
                    expect_verdict(VERDICT_INCOMPLETE, walk_target);
            end
            restart_walk();
        end else begin
            walk_pos = sat_sum(walk_pos, 1);
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Predict on every accepted byte, check every accepted result.
    always @(posedge aclk) begin : monitor
        gbsw_out_t due;
        if (aresetn) begin
            if (s_valid && s_ready) walk_gif_byte(s_data);
            if (m_valid && m_ready) begin
                if (verdicts_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result verdict=%0d length=%0d",
                                              m_data.verdict, m_data.parsed_length));
                end else begin
                    due = verdicts_due.pop_front();
                    if (m_data.verdict !== due.verdict)
                        report_mismatch($sformatf("verdict %0d, want %0d",
                                                  m_data.verdict, due.verdict));
                    if (m_data.parsed_length !== due.parsed_length)
                        report_mismatch($sformatf("length %0d, want %0d",
                                                  m_data.parsed_length, due.parsed_length));
                    seen_by_verdict[int'(due.verdict)]++;
                    verdicts_seen++;
                end
            end
        end
    end

    // Result side: random stall bursts on m_ready, started only while idling.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idling && $urandom_range(0, 4) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, verdicts_due.size());
        $display("CHECK FAILED");
        $finish;
    end

    // File builders.
    function automatic void put_random(int n);
        repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void begin_file(bit v89, logic [7:0] screen_flags);
        file_bytes.delete();
        for (int i = 0; i < 6; i++) file_bytes.push_back(sig_byte(i, v89));
        put_random(4);
        file_bytes.push_back(screen_flags);
        put_random(2);
        put_random(int'(color_table_len(screen_flags)));
    endfunction

    function automatic void put_sub_blocks(int count, int max_len);
        int len;
        repeat (count) begin
            len = $urandom_range(1, max_len);
            file_bytes.push_back(8'(len));
            put_random(len);
        end
        file_bytes.push_back(8'h00);
    endfunction

    function automatic void put_image(logic [7:0] local_flags, int count, int max_len);
        file_bytes.push_back(BYTE_IMAGE);
        put_random(8);
        file_bytes.push_back(local_flags);
        put_random(int'(color_table_len(local_flags)));
        file_bytes.push_back(8'($urandom_range(2, 8)));
        put_sub_blocks(count, max_len);
    endfunction

    function automatic void put_extension(int count, int max_len);
        file_bytes.push_back(BYTE_EXT);
        put_random(1);
        put_sub_blocks(count, max_len);
    endfunction

    // Mostly small color tables; now and then up to the full 256 entries.
    function automatic logic [7:0] random_table_flags();
        logic [7:0] f;
        f = 8'($urandom);
        f[2:0] = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(4, 7))
                                              : 3'($urandom_range(0, 3));
        return f;
    endfunction

    task automatic push_byte(logic [7:0] b, logic is_last);
        if (idling && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, last_byte: is_last};
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Send the first cut bytes of the file (all of it when cut is 0 or too large).
    task automatic send_file(int cut);
        int n;
        n = (cut > 0 && cut < file_bytes.size()) ? cut : file_bytes.size();
        for (int i = 0; i < n; i++) push_byte(file_bytes[i], i == n - 1);
        files_sent++;
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due.size() != 0) @(posedge aclk);
    endtask

    task automatic random_file();
        int         kind;
        int         ending;
        int         idx;
        logic [7:0] junk;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            file_bytes.delete();
            put_random($urandom_range(1, 24));
            send_file(0);
        end else if (kind < 24) begin
            // damaged signature or header cut short
            begin_file(1'($urandom_range(0, 1)), random_table_flags());
            if ($urandom_range(0, 1)) begin
                idx = $urandom_range(0, 5);
                file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
            end
            put_random($urandom_range(0, 6));
            send_file($urandom_range(1, 16));
        end else begin
            begin_file(1'($urandom_range(0, 1)), random_table_flags());
            repeat ($urandom_range(0, 4)) begin
                if ($urandom_range(0, 1))
                    put_image(random_table_flags(), $urandom_range(0, 3),
                              ($urandom_range(0, 14) == 0) ? 255 : 8);
                else
                    put_extension($urandom_range(0, 3),
                                  ($urandom_range(0, 14) == 0) ? 255 : 8);
            end
            ending = $urandom_range(0, 9);
            if (ending < 5) begin
                file_bytes.push_back(BYTE_TRAILER);
                put_random($urandom_range(0, 4));
                send_file(0);
            end else if (ending < 7) begin
                do junk = 8'($urandom);
                while (junk == BYTE_TRAILER || junk == BYTE_IMAGE || junk == BYTE_EXT);
                file_bytes.push_back(junk);
                put_random($urandom_range(0, 4));
                send_file(0);
            end else begin
                send_file($urandom_range(1, file_bytes.size()));
            end
        end
    endtask

    task automatic test_headers();
        begin_file(1'b0, 8'h00);
        file_bytes.push_back(BYTE_TRAILER);
        send_file(0);
        begin_file(1'b1, 8'h80);
        file_bytes.push_back(BYTE_TRAILER);
        send_file(0);
        // largest global table, cut after the first byte of that table
        begin_file(1'b0, 8'hFF);
        send_file(14);
    endtask

    task automatic test_bad_signature();
        for (int pos = 0; pos < 6; pos++) begin
            begin_file(1'(pos % 2), 8'h00);
            file_bytes[pos] = (pos % 2) ? 8'hFF : 8'h00;
            file_bytes.push_back(BYTE_TRAILER);
            send_file(0);
        end
    endtask

    task automatic test_short_files();
        begin_file(1'b1, 8'h00);
        file_bytes.push_back(BYTE_TRAILER);
        send_file(1);
        send_file(6);
        send_file(13);
        file_bytes[13] = BYTE_EXT;
        send_file(14);
    endtask

    task automatic test_unknown_block();
        begin_file(1'b0, 8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(BYTE_TRAILER);
        send_file(0);
        begin_file(1'b1, 8'h00);
        file_bytes.push_back(8'hFF);
        put_random(3);
        send_file(0);
    endtask

    // End the file in every waiting state of the walk.
    task automatic test_truncated_walk();
        int img_at;
        int ext_at;
        int cuts[$];
        begin_file(1'b1, 8'h80);
        img_at = file_bytes.size();
        put_image(8'h81, 2, 4);
        ext_at = file_bytes.size();
        put_extension(1, 3);
        file_bytes.push_back(BYTE_TRAILER);
        cuts = '{img_at, img_at + 1, img_at + 5, img_at + 10, img_at + 23, img_at + 24,
                 ext_at + 1, ext_at + 2, ext_at + 3, 0};
        foreach (cuts[i]) send_file(cuts[i]);
    endtask

    task automatic test_result_drain();
        repeat (12) begin
            wait_results();
            random_file();
        end
    endtask

    task automatic test_random_traffic();
        while (bytes_sent < 1250) random_file();
    endtask

    task automatic test_streaming();
        idling = 1'b0;
        while (bytes_sent < 1650 || verdicts_seen + verdicts_due.size() < 60) random_file();
    endtask

    initial begin
        restart_walk();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_headers();
        test_bad_signature();
        test_short_files();
        test_unknown_block();
        test_truncated_walk();
        test_result_drain();
        test_random_traffic();
        test_streaming();
        wait_results();
        repeat (8) @(posedge aclk);
        $display("%0d bytes in %0d files; verdicts: %0d invalid, %0d complete, %0d incomplete",
                 bytes_sent, files_sent, seen_by_verdict[0], seen_by_verdict[1],
                 seen_by_verdict[2]);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/gbsw_pkg.sv
rtl/gif_block_structure_walker.sv
tb/gif_block_structure_walker_test.sv
